### hdl/sorted_key_table_defines.svh
// Assertion macros for the sorted key table checker.
// Each macro expects the signals i_clk and i_rst_n in the using scope.
`ifndef SORTED_KEY_TABLE_DEFINES_SVH
`define SORTED_KEY_TABLE_DEFINES_SVH

// The antecedent holds in a cycle, so the consequent holds in the same cycle.
`define SKT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent holds in a cycle, so the consequent holds in the next cycle.
`define SKT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/skt_pkg.sv
// Shared types, codes and constants of the sorted key table.
// Used by skt_ctrl, skt_dp, sorted_key_table, skt_checker and tb_top; depends on nothing.
package skt_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int TYPE_COUNT    = 16;
    localparam int KEY_W         = 32;
    localparam int KIND_W        = 8;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 3;

    typedef logic [OP_W-1:0]     t_op;
    typedef logic [STATUS_W-1:0] t_status;

    // Request codes.
    localparam t_op OP_LOOKUP = 2'd0;
    localparam t_op OP_INSERT = 2'd1;
    localparam t_op OP_REMOVE = 2'd2;

    // Result codes.
    localparam t_status ST_OK      = 3'd0;
    localparam t_status ST_DUP     = 3'd1;
    localparam t_status ST_MISSING = 3'd2;
    localparam t_status ST_FULL    = 3'd3;
    localparam t_status ST_BAD     = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // latch the request, open the search window
        logic srch_rd;   // read the middle entry of the window
        logic srch_cmp;  // narrow the window with the entry just read
        logic init_up;   // shift pointer to the entry count
        logic init_dn;   // shift pointer to the found position
        logic step_up;   // move one entry up by one place
        logic step_dn;   // move one entry down by one place
        logic place;     // write the new entry, count up
        logic shrink;    // count down
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_op  op;
        logic lo_lt_hi;
        logic found;
        logic bad_ins;
        logic full;
        logic up_done;
        logic dn_done;
    } t_dp_stat;

endpackage

### hdl/sorted_key_table.sv
// Sorted key table: each request starts with a binary search of at most clog2(count+1) steps
// (7 for 64 entries), each a registered memory read and a compare. A lookup then gives the result
// beat; a successful insert shifts the entries from the found position up one place and writes
// the new entry, a successful remove shifts the entries above the found one down one place.
// A new start is taken in the result beat's cycle; o_valid marks each result for one cycle and
// cannot be stalled. Synchronous active-low reset empties the table, not the entry contents.
module sorted_key_table #(
    parameter int TABLE_DEPTH = skt_pkg::DEPTH_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [skt_pkg::OP_W-1:0]         i_operation,
    input  logic signed [skt_pkg::KEY_W-1:0] i_key,
    input  logic [skt_pkg::KIND_W-1:0]       i_kind,
    output logic                             o_valid,
    output logic [skt_pkg::STATUS_W-1:0]     o_status
);

    skt_pkg::t_cmd     cmd;
    skt_pkg::t_dp_stat dp_stat;

    // Sequencer.
    skt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_status (o_status),
        .i_stat   (dp_stat),
        .o_cmd    (cmd)
    );

    // Table storage and search arithmetic.
    skt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_operation (i_operation),
        .i_key       (i_key),
        .i_kind      (i_kind),
        .i_cmd       (cmd),
        .o_stat      (dp_stat)
    );

endmodule

### hdl/skt_ctrl.sv
// Controller state machine of the sorted key table: sequences search,
// shift and result beat. Depends on skt_pkg; drives skt_dp by commands.
module skt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    output logic               o_valid,
    output skt_pkg::t_status   o_status,
    input  skt_pkg::t_dp_stat  i_stat,
    output skt_pkg::t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        IDLE,
        SRCH_RD,
        SRCH_CMP,
        SHIFT_UP,
        PLACE,
        SHIFT_DN
    } t_state;

    t_state           r_state, n_state;
    logic             r_busy, n_busy;
    logic             r_valid, n_valid;
    skt_pkg::t_status r_status, n_status;

    // Next state, commands and result.
    always_comb begin
        o_cmd    = '0;
        n_state  = r_state;
        n_busy   = r_busy;
        n_valid  = 1'b0;
        n_status = r_status;
        case (r_state)
            IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = SRCH_RD;
                    n_busy     = 1'b1;
                end
            end
            SRCH_RD: begin
                if (i_stat.lo_lt_hi) begin
                    o_cmd.srch_rd = 1'b1;
                    n_state       = SRCH_CMP;
                end else begin
                    // Search finished: decide what the request does.
                    n_state = IDLE;
                    n_busy  = 1'b0;
                    n_valid = 1'b1;
                    case (i_stat.op)
                        skt_pkg::OP_LOOKUP: begin
                            n_status = i_stat.found ? skt_pkg::ST_OK : skt_pkg::ST_MISSING;
                        end
                        skt_pkg::OP_INSERT: begin
                            if (i_stat.bad_ins) begin
                                n_status = skt_pkg::ST_BAD;
                            end else if (i_stat.found) begin
                                n_status = skt_pkg::ST_DUP;
                            end else if (i_stat.full) begin
                                n_status = skt_pkg::ST_FULL;
                            end else begin
                                o_cmd.init_up = 1'b1;
                                n_state       = SHIFT_UP;
                                n_busy        = 1'b1;
                                n_valid       = 1'b0;
                            end
                        end
                        skt_pkg::OP_REMOVE: begin
                            if (!i_stat.found) begin
                                n_status = skt_pkg::ST_MISSING;
                            end else begin
                                o_cmd.init_dn = 1'b1;
                                n_state       = SHIFT_DN;
                                n_busy        = 1'b1;
                                n_valid       = 1'b0;
                            end
                        end
                        default: begin
                            n_status = skt_pkg::ST_BAD;
                        end
                    endcase
                end
            end
            SRCH_CMP: begin
                o_cmd.srch_cmp = 1'b1;
                n_state        = SRCH_RD;
            end
            SHIFT_UP: begin
                if (!i_stat.up_done) begin
                    o_cmd.step_up = 1'b1;
                end else begin
                    n_state = PLACE;
                end
            end
            PLACE: begin
                o_cmd.place = 1'b1;
                n_state     = IDLE;
                n_busy      = 1'b0;
                n_valid     = 1'b1;
                n_status    = skt_pkg::ST_OK;
            end
            SHIFT_DN: begin
                if (!i_stat.dn_done) begin
                    o_cmd.step_dn = 1'b1;
                end else begin
                    o_cmd.shrink = 1'b1;
                    n_state      = IDLE;
                    n_busy       = 1'b0;
                    n_valid      = 1'b1;
                    n_status     = skt_pkg::ST_OK;
                end
            end
            default: begin
                n_state = IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= IDLE;
            r_busy   <= 1'b0;
            r_valid  <= 1'b0;
            r_status <= skt_pkg::ST_OK;
        end else begin
            r_state  <= n_state;
            r_busy   <= n_busy;
            r_valid  <= n_valid;
            r_status <= n_status;
        end
    end

    assign busy     = r_busy;
    assign o_valid  = r_valid;
    assign o_status = r_status;

endmodule

### hdl/skt_dp.sv
// Datapath of the sorted key table: entry memory, entry count, search
// window and shift pointer. Depends on skt_pkg; commanded by skt_ctrl.
module skt_dp #(
    parameter int TABLE_DEPTH = skt_pkg::DEPTH_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  skt_pkg::t_op                     i_operation,
    input  logic signed [skt_pkg::KEY_W-1:0] i_key,
    input  logic [skt_pkg::KIND_W-1:0]       i_kind,
    input  skt_pkg::t_cmd                    i_cmd,
    output skt_pkg::t_dp_stat                o_stat
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // Entry memory, one write and one registered read port.
    logic [skt_pkg::KEY_W-1:0]  mem_key  [TABLE_DEPTH];
    logic [skt_pkg::KIND_W-1:0] mem_kind [TABLE_DEPTH];

    logic [CW-1:0]               r_cnt, r_lo, r_hi, r_ptr;
    logic                        r_found;
    skt_pkg::t_op                r_op;
    logic signed [skt_pkg::KEY_W-1:0] r_key;
    logic [skt_pkg::KIND_W-1:0]  r_kind;
    logic [skt_pkg::KEY_W-1:0]   r_rd_key;
    logic [skt_pkg::KIND_W-1:0]  r_rd_kind;
    logic                        r_wr_pend;
    logic [AW-1:0]               r_wr_addr;

    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid;
    logic [CW-1:0] ptr_dec, ptr_inc;
    logic [AW-1:0] rd_addr;
    logic          rd_en;
    logic          rd_lt;

    // Window middle and shift neighbors.
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[CW:1];
    assign ptr_dec = r_ptr - 1'b1;
    assign ptr_inc = r_ptr + 1'b1;
    assign rd_lt   = $signed(r_rd_key) < r_key;

    always_comb begin
        rd_addr = mid[AW-1:0];
        if (i_cmd.step_up) begin
            rd_addr = ptr_dec[AW-1:0];
        end else if (i_cmd.step_dn) begin
            rd_addr = ptr_inc[AW-1:0];
        end
    end
    assign rd_en = i_cmd.srch_rd | i_cmd.step_up | i_cmd.step_dn;

    // Memory port: a shift write lands in the cycle after its read.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_key  <= mem_key[rd_addr];
            r_rd_kind <= mem_kind[rd_addr];
        end
        if (r_wr_pend) begin
            mem_key[r_wr_addr]  <= r_rd_key;
            mem_kind[r_wr_addr] <= r_rd_kind;
        end else if (i_cmd.place) begin
            mem_key[r_lo[AW-1:0]]  <= r_key;
            mem_kind[r_lo[AW-1:0]] <= r_kind;
        end
    end

    // Control state: entry count and pending shift write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_wr_pend <= 1'b0;
        end else begin
            r_wr_pend <= i_cmd.step_up | i_cmd.step_dn;
            if (i_cmd.place) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_cmd.shrink) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Request, search window and shift pointer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_operation;
            r_key   <= i_key;
            r_kind  <= i_kind;
            r_lo    <= '0;
            r_hi    <= r_cnt;
            r_found <= 1'b0;
        end
        // Lower-bound search; the last upper-bound hit decides the match.
        if (i_cmd.srch_cmp) begin
            if (rd_lt) begin
                r_lo <= mid + 1'b1;
            end else begin
                r_hi    <= mid;
                r_found <= (r_rd_key == r_key);
            end
        end
        if (i_cmd.init_up) begin
            r_ptr <= r_cnt;
        end else if (i_cmd.init_dn) begin
            r_ptr <= r_lo;
        end else if (i_cmd.step_up) begin
            r_ptr     <= ptr_dec;
            r_wr_addr <= r_ptr[AW-1:0];
        end else if (i_cmd.step_dn) begin
            r_ptr     <= ptr_inc;
            r_wr_addr <= r_ptr[AW-1:0];
        end
    end

    // Status for the controller.
    assign o_stat.op       = r_op;
    assign o_stat.lo_lt_hi = r_lo < r_hi;
    assign o_stat.found    = r_found;
    assign o_stat.bad_ins  = r_key[skt_pkg::KEY_W-1]
                           | ({1'b0, r_kind} >= (skt_pkg::KIND_W + 1)'(skt_pkg::TYPE_COUNT));
    assign o_stat.full     = r_cnt == CW'(TABLE_DEPTH);
    assign o_stat.up_done  = r_ptr == r_lo;
    assign o_stat.dn_done  = ({1'b0, r_ptr} + 1'b1) >= {1'b0, r_cnt};

endmodule

### hdl/skt_checker.sv
// Port-level checker of the sorted key table, bound to the top level.
// Depends on the macros in sorted_key_table_defines.svh.
`include "sorted_key_table_defines.svh"

module skt_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_valid,
    input logic [skt_pkg::STATUS_W-1:0] o_status
);

    // An accepted request keeps the block busy in the next cycle.
    `SKT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")

    // A result beat comes only once the work is finished.
    `SKT_ASSERT_SAME(a_valid_idle, o_valid, !busy, "result beat while busy")

    // Busy drops exactly with the result beat.
    `SKT_ASSERT_SAME(a_fell_valid, $fell(busy), o_valid, "busy dropped without a result beat")

    // One request gives one beat: never two in a row.
    `SKT_ASSERT_NEXT(a_single_beat, o_valid, !o_valid, "result beat repeated")

    // Status carries a defined code.
    `SKT_ASSERT_SAME(a_status_code, o_valid, o_status <= skt_pkg::ST_BAD, "undefined status code")

endmodule

bind sorted_key_table skt_checker u_skt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_status (o_status)
);

### tb/tb_top.sv
// Self-checking testbench for sorted_key_table: lookup, insert and remove requests
// against a sorted table of signed keys. Depends on skt_pkg and the sorted_key_table RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int          DEPTH          = skt_pkg::DEPTH_DEFAULT;
    localparam skt_pkg::t_op OP_UNUSED     = 2'd3;
    localparam int          RANDOM_ITEMS   = 900;
    localparam int          PHASE_ITEMS    = 180;
    localparam int          DRAIN_CYCLES   = 90;
    localparam int          WATCHDOG_LIMIT = 1000;

    // Tracks the table contents and predicts the status of every accepted request beat.
    class key_table_scoreboard;
        logic signed [skt_pkg::KEY_W-1:0] keys [DEPTH];
        logic [skt_pkg::KIND_W-1:0]       kinds [DEPTH];
        int                               count;
        int                               peak;
        int                               errors;
        int                               accepted;
        int                               tally [5];
        skt_pkg::t_status                 status_q [$];

        function void note_request(skt_pkg::t_op op, logic signed [skt_pkg::KEY_W-1:0] key,
                                   logic [skt_pkg::KIND_W-1:0] kind);
            int               lo;
            int               hi;
            int               mid;
            int               i;
            bit               found;
            skt_pkg::t_status st;
            // Binary search for the first entry that is not below the key.
            lo = 0;
            hi = count;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (keys[mid] < key) begin
                    lo = mid + 1;
                end else begin
                    hi = mid;
                end
            end
            found = (lo < count) && (keys[lo] == key);

            case (op)
                skt_pkg::OP_LOOKUP: st = found ? skt_pkg::ST_OK : skt_pkg::ST_MISSING;
                skt_pkg::OP_INSERT: begin
                    if (key < 0 || kind >= skt_pkg::TYPE_COUNT) begin
                        st = skt_pkg::ST_BAD;
                    end else if (found) begin
                        st = skt_pkg::ST_DUP;
                    end else if (count >= DEPTH) begin
                        st = skt_pkg::ST_FULL;
                    end else begin
                        for (i = count; i > lo; i--) begin
                            keys[i]  = keys[i-1];
                            kinds[i] = kinds[i-1];
                        end
                        keys[lo]  = key;
                        kinds[lo] = kind;
                        count++;
                        st = skt_pkg::ST_OK;
                    end
                end
                skt_pkg::OP_REMOVE: begin
                    if (!found) begin
                        st = skt_pkg::ST_MISSING;
                    end else begin
                        for (i = lo; i + 1 < count; i++) begin
                            keys[i]  = keys[i+1];
                            kinds[i] = kinds[i+1];
                        end
                        count--;
                        st = skt_pkg::ST_OK;
                    end
                end
                default: st = skt_pkg::ST_BAD;
            endcase

            accepted++;
            tally[st]++;
            if (count > peak) begin
                peak = count;
            end
            status_q.push_back(st);
        endfunction

        function void check_result(skt_pkg::t_status got);
            skt_pkg::t_status want;
            if (status_q.size() == 0) begin
                $display("%0t ns: status %0d arrived with no request outstanding", $time, got);
                errors++;
            end else begin
                want = status_q.pop_front();
                if (got !== want) begin
                    $display("%0t ns: status mismatch, expected %0d, actual %0d",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction

        function logic signed [skt_pkg::KEY_W-1:0] key_at(int idx);
            return keys[idx];
        endfunction
    endclass

    logic                             i_clk;
    logic                             i_rst_n     = 1'b0;
    logic                             start       = 1'b0;
    logic                             busy;
    skt_pkg::t_op                     i_operation = skt_pkg::OP_LOOKUP;
    logic signed [skt_pkg::KEY_W-1:0] i_key       = '0;
    logic [skt_pkg::KIND_W-1:0]       i_kind      = '0;
    logic                             o_valid;
    skt_pkg::t_status                 o_status;

    key_table_scoreboard sb = new();
    int                  burst_left = 0;
    int                  idle_cycles = 0;

    sorted_key_table #(
        .TABLE_DEPTH(DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_operation(i_operation),
        .i_key      (i_key),
        .i_kind     (i_kind),
        .o_valid    (o_valid),
        .o_status   (o_status)
    );

    // Clock with a 12 ns period; it starts low so the first rising edge is at 6 ns.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Every result beat is checked against the oldest predicted status.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            sb.check_result(o_status);
        end
    end

    // Ends the run when neither a request nor a result beat moves for too long.
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_valid === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb_top: errors");
            $finish;
        end
    end

    // Presents one request beat, waits for it to be taken, then paces the next one.
    // Requests go out in bursts; between bursts start may drop for a random gap.
    task automatic send(input skt_pkg::t_op op, input logic signed [skt_pkg::KEY_W-1:0] key,
                        input logic [skt_pkg::KIND_W-1:0] kind);
        int r;
        int gap;
        start       <= 1'b1;
        i_operation <= op;
        i_key       <= key;
        i_kind      <= kind;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_request(op, key, kind);

        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 20);
            r = $urandom_range(0, 99);
            if (r < 30) begin
                gap = 0;
            end else if (r < 80) begin
                gap = $urandom_range(1, 5);
            end else begin
                gap = $urandom_range(6, 90);
            end
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        bit                               grow;
        int                               n;
        int                               r;
        int                               present_pct;
        skt_pkg::t_op                     op;
        logic signed [skt_pkg::KEY_W-1:0] key;
        logic [skt_pkg::KIND_W-1:0]       kind;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests: empty table, rejected inserts, extreme keys, duplicates.
        send(skt_pkg::OP_LOOKUP, 32'sd0, 8'd0);
        send(skt_pkg::OP_REMOVE, 32'sd5, 8'd0);
        send(skt_pkg::OP_INSERT, -32'sd1, 8'd0);
        send(skt_pkg::OP_INSERT, 32'sh8000_0000, 8'd3);
        send(skt_pkg::OP_INSERT, 32'sd10, 8'd16);
        send(skt_pkg::OP_INSERT, 32'sd10, 8'd255);
        send(OP_UNUSED, 32'sd0, 8'd0);
        send(skt_pkg::OP_INSERT, 32'sd0, 8'd0);
        send(skt_pkg::OP_INSERT, 32'sh7FFF_FFFF, 8'd15);
        send(skt_pkg::OP_INSERT, 32'sd1000, 8'd7);
        send(skt_pkg::OP_INSERT, 32'sd1000, 8'd2);
        // A bad kind wins over a duplicate key.
        send(skt_pkg::OP_INSERT, 32'sd0, 8'd20);
        send(skt_pkg::OP_LOOKUP, 32'sh7FFF_FFFF, 8'd0);
        send(skt_pkg::OP_LOOKUP, 32'sh8000_0000, 8'd0);
        send(skt_pkg::OP_LOOKUP, -32'sd1, 8'd0);
        send(skt_pkg::OP_LOOKUP, 32'sd999, 8'd0);
        send(skt_pkg::OP_REMOVE, 32'sd1000, 8'd255);
        send(skt_pkg::OP_REMOVE, 32'sd1000, 8'd0);
        send(skt_pkg::OP_LOOKUP, 32'sd0, 8'hFF);
        send(OP_UNUSED, 32'sh7FFF_FFFF, 8'hFF);
        send(skt_pkg::OP_REMOVE, 32'sd0, 8'd0);
        send(skt_pkg::OP_REMOVE, 32'sh7FFF_FFFF, 8'd0);
        send(skt_pkg::OP_LOOKUP, 32'sh7FFF_FFFF, 8'd0);

        // Random requests in alternating phases: one is mostly inserts to fill the table,
        // the next mostly removes to drain it.
        grow = 1'b0;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PHASE_ITEMS == 0) begin
                grow = ~grow;
            end

            r = $urandom_range(0, 99);
            if (grow) begin
                op = (r < 70) ? skt_pkg::OP_INSERT : (r < 82) ? skt_pkg::OP_LOOKUP :
                     (r < 96) ? skt_pkg::OP_REMOVE : OP_UNUSED;
            end else begin
                op = (r < 12) ? skt_pkg::OP_INSERT : (r < 30) ? skt_pkg::OP_LOOKUP :
                     (r < 97) ? skt_pkg::OP_REMOVE : OP_UNUSED;
            end

            // Fresh keys while filling, keys already held while draining.
            if (op == skt_pkg::OP_INSERT && grow) begin
                present_pct = 15;
            end else if (op == skt_pkg::OP_REMOVE && !grow) begin
                present_pct = 80;
            end else begin
                present_pct = 45;
            end

            r = $urandom_range(0, 99);
            if (r < present_pct && sb.count > 0) begin
                key = sb.key_at($urandom_range(0, sb.count - 1));
            end else if (r < 75) begin
                key = $urandom_range(0, 4095);
            end else if (r < 90) begin
                key = $urandom & 32'h7FFF_FFFF;
            end else begin
                key = $urandom;
            end

            if ($urandom_range(0, 99) < 90) begin
                kind = (skt_pkg::KIND_W)'($urandom_range(0, skt_pkg::TYPE_COUNT - 1));
            end else begin
                kind = (skt_pkg::KIND_W)'($urandom_range(0, 255));
            end

            send(op, key, kind);
        end

        // Let every outstanding result beat arrive, then watch for strays.
        start <= 1'b0;
        while (sb.status_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests: %0d ok, %0d duplicate, %0d not found, %0d full, %0d bad.",
                 sb.accepted, sb.tally[skt_pkg::ST_OK], sb.tally[skt_pkg::ST_DUP],
                 sb.tally[skt_pkg::ST_MISSING], sb.tally[skt_pkg::ST_FULL],
                 sb.tally[skt_pkg::ST_BAD]);
        $display("The table held at most %0d of %0d entries; %0d mismatches seen.",
                 sb.peak, DEPTH, sb.errors);
        if (sb.errors == 0 && sb.status_q.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/skt_pkg.sv
hdl/skt_ctrl.sv
hdl/skt_dp.sv
hdl/sorted_key_table.sv
hdl/skt_checker.sv
tb/tb_top.sv
